/* hdl/bootloader_packet_command_engine_core_defines.svh */
// assertion macros for the bootloader packet command engine
// depends on nothing; the asserting file supplies clk and rst_n in its scope
`ifndef BOOTLOADER_PACKET_COMMAND_ENGINE_CORE_DEFINES_SVH
`define BOOTLOADER_PACKET_COMMAND_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BPCE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpce assertion failed");
// antecedent implies consequent in the next cycle
`define BPCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpce assertion failed");
`else
`define BPCE_ASSERT_IMPL(lbl, ante, cons)
`define BPCE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/bpce_pkg.sv */
// shared types, codes and constants of the bootloader packet command engine
// no dependencies
package bpce_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int PACKET_BYTES_DEF = 32;
    localparam int CHUNK_BYTES_DEF  = 30;

    localparam logic [7:0] HDR_CMD      = 8'd254;
    localparam logic [7:0] SUB_ENTER    = 8'd254;
    localparam logic [7:0] SUB_FLASH    = 8'd252;
    localparam logic [7:0] SUB_TO_APP   = 8'd253;
    localparam logic [7:0] SUB_EXIT     = 8'd251;
    localparam logic [7:0] SUB_LOAD_MAX = 8'd34;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_FLASH = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // register indexes on the config port
    localparam logic REG_FIRST_BLOCK = 1'b0;
    localparam logic REG_BLOCK_LIMIT = 1'b1;

    localparam int CFG_ADDR_W = 3;
    localparam logic [31:0] FIRST_BLOCK_RESET = 32'd4;
    localparam logic [31:0] BLOCK_LIMIT_RESET = 32'd1024;

    localparam int Q_DEPTH = 3;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        EV_REPLY = 2'd0,
        EV_BOOT  = 2'd1,
        EV_WORD  = 2'd2
    } event_t;

    // control flags of the buffer stage
    typedef struct packed {
        logic   valid;
        logic   wr;
        logic   clear;
        logic   has_res;
        logic   is_word;
        logic   first;
        logic   last;
        event_t ev;
        logic   status;
    } stage_t;

    typedef struct packed {
        logic serving;
        logic checking;
    } ctrl_status_t;

    typedef struct packed {
        event_t      ev;
        logic        status;
        logic [31:0] flash_block;
        logic [7:0]  word_index;
        logic [31:0] new_word;
        logic        erase;
        logic        write;
        logic        last;
    } result_t;

endpackage

/* hdl/bpce_ram.sv */
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module bpce_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bpce_ctrl.sv */
// packet decoder and check sequencer: updates control state on each accepted beat
// and issues the buffer-stage command; depends on bpce_pkg
module bpce_ctrl
    import bpce_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF,
    localparam int ROWS        = BUFFER_BYTES / 4,
    localparam int ROW_W       = $clog2(ROWS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               op,
    input  logic [4:0]         byte_index,
    input  logic [7:0]         byte_value,
    input  logic [31:0]        old_word,
    input  logic [31:0]        first_block,
    input  logic [31:0]        block_limit,
    output logic               rd_en,
    output logic [ROW_W-1:0]   rd_row,
    output stage_t             st,
    output logic [ROW_W-1:0]   row,
    output logic [1:0]         lane,
    output logic [7:0]         byte_out,
    output logic [31:0]        old_out,
    output logic [31:0]        block_out,
    output logic [7:0]         widx,
    output ctrl_status_t       status
);

    localparam int ADDR_W = $clog2((int'(SUB_LOAD_MAX) + 1) * CHUNK_BYTES + BUFFER_BYTES + 1);

    logic              serving_reg, serving_next;
    logic              header_reg, header_next;
    logic [7:0]        sub_reg, sub_next;
    logic [31:0]       block_reg, block_next;
    logic              checking_reg, checking_next;
    logic [ROW_W-1:0]  cidx_reg, cidx_next;
    stage_t            st_reg, st_next;
    logic [ROW_W-1:0]  row_reg;
    logic [1:0]        lane_reg;
    logic [7:0]        byte_reg;
    logic [31:0]       old_reg;
    logic [31:0]       blk_out_reg;
    logic [7:0]        widx_reg;

    logic [ADDR_W-1:0] addr;
    logic              in_chunk;
    logic              beyond;
    logic              is_last;

    always_comb
    begin
        serving_next  = serving_reg;
        header_next   = header_reg;
        sub_next      = sub_reg;
        block_next    = block_reg;
        checking_next = checking_reg;
        cidx_next     = cidx_reg;
        st_next       = '0;
        st_next.ev    = EV_REPLY;
        st_next.valid = accept;

        beyond   = ({1'b0, byte_index} >= 6'(PACKET_BYTES));
        is_last  = (byte_index == 5'(PACKET_BYTES - 1));
        in_chunk = ({1'b0, byte_index} >= 6'd2) &&
                   ({1'b0, byte_index} < 6'(2 + CHUNK_BYTES));

        if (byte_index == 5'd0)
        begin
            header_next = (byte_value == HDR_CMD);
        end
        if (byte_index == 5'd1)
        begin
            sub_next = byte_value;
        end
        case (byte_index)
            5'd2:    block_next[7:0]   = byte_value;
            5'd3:    block_next[15:8]  = byte_value;
            5'd4:    block_next[23:16] = byte_value;
            5'd5:    block_next[31:24] = byte_value;
            default: block_next        = block_reg;
        endcase

        addr = ADDR_W'(sub_next[5:0]) * ADDR_W'(CHUNK_BYTES) + ADDR_W'(byte_index)
               - ADDR_W'(2);

        if (op == OP_FLASH)
        begin
            rd_row = cidx_reg;
        end
        else
        begin
            rd_row = addr[ROW_W+1:2];
        end
        rd_en = accept;

        if (!accept)
        begin
            // keep state as is
            header_next = header_reg;
            sub_next    = sub_reg;
            block_next  = block_reg;
        end
        else if (op == OP_FLASH)
        begin
            header_next = header_reg;
            sub_next    = sub_reg;
            block_next  = block_reg;
            if (checking_reg)
            begin
                st_next.has_res = 1'b1;
                st_next.is_word = 1'b1;
                st_next.ev      = EV_WORD;
                st_next.first   = (cidx_reg == '0);
                st_next.last    = (cidx_reg == ROW_W'(ROWS - 1));
                if (st_next.last)
                begin
                    checking_next = 1'b0;
                    cidx_next     = '0;
                end
                else
                begin
                    cidx_next = cidx_reg + 1'b1;
                end
            end
        end
        else if (checking_reg || beyond)
        begin
            header_next = header_reg;
            sub_next    = sub_reg;
            block_next  = block_reg;
        end
        else
        begin
            if (serving_reg && header_next && (sub_next <= SUB_LOAD_MAX) && in_chunk &&
                (addr < ADDR_W'(BUFFER_BYTES)))
            begin
                st_next.wr = 1'b1;
            end
            if (is_last)
            begin
                if (!serving_reg)
                begin
                    if (header_next && (sub_next == SUB_ENTER))
                    begin
                        serving_next    = 1'b1;
                        st_next.clear   = 1'b1;
                        st_next.has_res = 1'b1;
                        st_next.ev      = EV_REPLY;
                        st_next.status  = STATUS_OK;
                    end
                    else
                    begin
                        st_next.clear   = 1'b1;
                        st_next.has_res = 1'b1;
                        st_next.ev      = EV_BOOT;
                    end
                end
                else if (!header_next)
                begin
                    serving_next    = 1'b0;
                    st_next.clear   = 1'b1;
                    st_next.has_res = 1'b1;
                    st_next.ev      = EV_BOOT;
                end
                else if (sub_next <= SUB_LOAD_MAX)
                begin
                    // load packet, nothing to report
                end
                else if (sub_next == SUB_FLASH)
                begin
                    if ((block_next < first_block) || (block_next >= block_limit))
                    begin
                        st_next.clear   = 1'b1;
                        st_next.has_res = 1'b1;
                        st_next.ev      = EV_REPLY;
                        st_next.status  = STATUS_BAD;
                    end
                    else
                    begin
                        checking_next = 1'b1;
                        cidx_next     = '0;
                    end
                end
                else if (sub_next inside {SUB_TO_APP, SUB_EXIT})
                begin
                    serving_next    = 1'b0;
                    st_next.clear   = 1'b1;
                    st_next.has_res = 1'b1;
                    st_next.ev      = EV_BOOT;
                end
                else if (sub_next == SUB_ENTER)
                begin
                    st_next.clear   = 1'b1;
                    st_next.has_res = 1'b1;
                    st_next.ev      = EV_REPLY;
                    st_next.status  = STATUS_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serving_reg  <= 1'b0;
            header_reg   <= 1'b0;
            sub_reg      <= '0;
            block_reg    <= '0;
            checking_reg <= 1'b0;
            cidx_reg     <= '0;
            st_reg       <= '0;
        end
        else
        begin
            serving_reg  <= serving_next;
            header_reg   <= header_next;
            sub_reg      <= sub_next;
            block_reg    <= block_next;
            checking_reg <= checking_next;
            cidx_reg     <= cidx_next;
            st_reg       <= st_next;
        end
    end

    // payload of the buffer stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg     <= rd_row;
            lane_reg    <= addr[1:0];
            byte_reg    <= byte_value;
            old_reg     <= old_word;
            blk_out_reg <= block_reg;
            widx_reg    <= 8'(cidx_reg);
        end
    end

    assign st              = st_reg;
    assign row             = row_reg;
    assign lane            = lane_reg;
    assign byte_out        = byte_reg;
    assign old_out         = old_reg;
    assign block_out       = blk_out_reg;
    assign widx            = widx_reg;
    assign status.serving  = serving_reg;
    assign status.checking = checking_reg;

endmodule

/* hdl/bpce_buf.sv */
// buffer stage: word ram with per-byte written marks, row valid bits,
// read-modify-write with forwarding, check word compare; depends on bpce_pkg, bpce_ram
module bpce_buf
    import bpce_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int ROWS        = BUFFER_BYTES / 4,
    localparam int ROW_W       = $clog2(ROWS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] rd_row,
    input  stage_t           st,
    input  logic [ROW_W-1:0] row,
    input  logic [1:0]       lane,
    input  logic [7:0]       byte_val,
    input  logic [31:0]      old_word,
    input  logic [31:0]      block,
    input  logic [7:0]       widx,
    output logic             push,
    output result_t          res
);

    localparam int WIDTH = 36;

    logic [ROWS-1:0]  row_valid_reg;
    logic             fwd_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             erase_acc_reg;
    logic             diff_acc_reg;

    logic [WIDTH-1:0] ram_q;
    logic [WIDTH-1:0] q;
    logic [3:0]       base_wr;
    logic [31:0]      merged_data;
    logic [WIDTH-1:0] merged;
    logic [31:0]      nw;
    logic             wr_en;
    logic             clear_all;
    logic             erase_cur;
    logic             diff_cur;

    always_comb
    begin
        q           = fwd_reg ? fwd_data_reg : ram_q;
        base_wr     = row_valid_reg[row] ? q[35:32] : 4'b0000;
        merged_data = q[31:0];
        merged_data[{lane, 3'b000} +: 8] = byte_val;
        merged      = {base_wr | (4'b0001 << lane), merged_data};
        for (int k = 0; k < 4; k++)
        begin
            nw[8*k +: 8] = base_wr[k] ? q[8*k +: 8] : 8'hff;
        end
        erase_cur = st.first ? (|(~old_word & nw)) : (erase_acc_reg | (|(~old_word & nw)));
        diff_cur  = st.first ? (old_word != nw) : (diff_acc_reg | (old_word != nw));

        wr_en     = st.valid && st.wr;
        clear_all = st.valid && (st.clear || (st.is_word && st.last));
        push      = st.valid && st.has_res;

        res             = '0;
        res.ev          = st.ev;
        res.status      = st.status;
        if (st.is_word)
        begin
            res.flash_block = block;
            res.word_index  = widx;
            res.new_word    = nw;
            res.last        = st.last;
            res.erase       = st.last && erase_cur;
            res.write       = st.last && diff_cur;
        end
    end

    bpce_ram #(
        .WIDTH (WIDTH),
        .DEPTH (ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row),
        .wr_data (merged),
        .rd_en   (rd_en),
        .rd_addr (rd_row),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            fwd_reg       <= 1'b0;
            erase_acc_reg <= 1'b0;
            diff_acc_reg  <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[row] <= 1'b1;
            end
            // same-row read during write sees the merged word next cycle
            fwd_reg <= wr_en && rd_en && (rd_row == row);
            if (st.valid && st.is_word)
            begin
                erase_acc_reg <= erase_cur;
                diff_acc_reg  <= diff_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= merged;
    end

endmodule

/* hdl/bpce_outq.sv */
// small result queue that decouples the buffer stage from the output channel
// depends on bpce_pkg
module bpce_outq
    import bpce_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           res_in,
    input  logic              pop_ready,
    output logic              out_valid,
    output result_t           res_out,
    output logic [QCNT_W-1:0] count
);

    result_t           ent_reg [Q_DEPTH];
    logic [QPTR_W-1:0] head_reg, head_next;
    logic [QPTR_W-1:0] tail_reg, tail_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    always_comb
    begin
        pop        = out_valid && pop_ready;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[tail_reg] <= res_in;
        end
    end

    assign out_valid = (count_reg != '0);
    assign res_out   = ent_reg[head_reg];
    assign count     = count_reg;

endmodule

/* hdl/bootloader_packet_command_engine_core.sv */
// top level of the bootloader packet command engine: config registers, apb port,
// decoder, buffer stage and result queue; depends on bpce_pkg and all bpce_* modules
//
// usage:
//   input channel (in_valid/in_ready): one beat per packet byte (op = 0, byte_index,
//   byte_value) or per old flash word while a check runs (op = 1, old_word).
//   a packet is acted on when its last byte arrives; a valid flash command then
//   expects BUFFER_BYTES/4 flash word beats, each answered by one check word.
//   output channel (out_valid/out_ready): one beat per status reply, boot request
//   or check word; beats that cause no result produce nothing.
//   a result goes through the buffer-stage register and the result queue to the output.
//   throughput: one input beat per cycle while the queue has room (in_ready high), set by the
//   single buffer ram port pair (one read and one write per cycle, same-row hazards forwarded).
//   reset: control state clears and all row valid bits clear at once, so the
//   buffer reads as all 0xff right away; no clearing pass is needed.
//   config registers are to be written over apb only while the engine is idle (not enforced).
//   receiver stall: up to three results wait in the output queue; in_ready drops
//   once the queue plus the result in flight would fill it.
`include "bootloader_packet_command_engine_core_defines.svh"

module bootloader_packet_command_engine_core
    import bpce_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = PACKET_BYTES_DEF,
    parameter int CHUNK_BYTES  = CHUNK_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // apb config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [4:0]            byte_index,
    input  logic [7:0]            byte_value,
    input  logic [31:0]           old_word,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            event_res,
    output logic                  reply_status,
    output logic [31:0]           flash_block,
    output logic [7:0]            word_index,
    output logic [31:0]           new_word,
    output logic                  erase_needed,
    output logic                  write_needed,
    output logic                  last
);

    localparam int ROWS  = BUFFER_BYTES / 4;
    localparam int ROW_W = $clog2(ROWS);

    // config registers
    logic [31:0]       first_block_reg;
    logic [31:0]       block_limit_reg;
    logic              cfg_wr;
    logic [31:0]       rd_sel;

    // pipeline links
    logic              accept;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    stage_t            s1_st;
    logic [ROW_W-1:0]  s1_row;
    logic [1:0]        s1_lane;
    logic [7:0]        s1_byte;
    logic [31:0]       s1_old;
    logic [31:0]       s1_block;
    logic [7:0]        s1_widx;
    ctrl_status_t      ctl_st;
    logic              res_push;
    result_t           res_new;
    result_t           q_res;
    logic [QCNT_W-1:0] q_count;

    // apb: zero-wait writes, register picked by address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_block_reg <= FIRST_BLOCK_RESET;
            block_limit_reg <= BLOCK_LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FIRST_BLOCK: first_block_reg <= pwdata;
                REG_BLOCK_LIMIT: block_limit_reg <= pwdata;
                default:         first_block_reg <= first_block_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_FIRST_BLOCK: rd_sel = first_block_reg;
            REG_BLOCK_LIMIT: rd_sel = block_limit_reg;
            default:         rd_sel = '0;
        endcase
        // unaligned reads return zero
        prdata = (paddr[1:0] == 2'b00) ? rd_sel : 32'd0;
    end

    // accept only if the queue can take this beat's result when it gets there
    assign in_ready = (({1'b0, q_count} + (QCNT_W + 1)'(s1_st.valid && s1_st.has_res))
                       < (QCNT_W + 1)'(Q_DEPTH));
    assign accept   = in_valid && in_ready;

    bpce_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .PACKET_BYTES (PACKET_BYTES),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .byte_index  (byte_index),
        .byte_value  (byte_value),
        .old_word    (old_word),
        .first_block (first_block_reg),
        .block_limit (block_limit_reg),
        .rd_en       (rd_en),
        .rd_row      (rd_row),
        .st          (s1_st),
        .row         (s1_row),
        .lane        (s1_lane),
        .byte_out    (s1_byte),
        .old_out     (s1_old),
        .block_out   (s1_block),
        .widx        (s1_widx),
        .status      (ctl_st)
    );

    bpce_buf #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_row   (rd_row),
        .st       (s1_st),
        .row      (s1_row),
        .lane     (s1_lane),
        .byte_val (s1_byte),
        .old_word (s1_old),
        .block    (s1_block),
        .widx     (s1_widx),
        .push     (res_push),
        .res      (res_new)
    );

    bpce_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .res_in    (res_new),
        .pop_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (q_res),
        .count     (q_count)
    );

    assign event_res    = 2'(q_res.ev);
    assign reply_status = q_res.status;
    assign flash_block  = q_res.flash_block;
    assign word_index   = q_res.word_index;
    assign new_word     = q_res.new_word;
    assign erase_needed = q_res.erase;
    assign write_needed = q_res.write;
    assign last         = q_res.last;

    // a full queue never receives another result
    `BPCE_ASSERT_IMPL(a_no_queue_overflow, q_count == QCNT_W'(Q_DEPTH), !res_push)
    // a flash word taken during a check yields a check word result next cycle
    `BPCE_ASSERT_NEXT(a_check_word_result, accept && (op == OP_FLASH) && ctl_st.checking, s1_st.valid && s1_st.is_word && s1_st.has_res)
    // a buffer load never clears the buffer or reports anything
    `BPCE_ASSERT_IMPL(a_load_is_silent, s1_st.valid && s1_st.wr, !s1_st.clear && !s1_st.has_res)

endmodule

/* tb/bootloader_packet_command_engine_core_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the bootloader packet command engine: mirrors the engine state,
// predicts each result beat and compares it field by field; depends on bpce_pkg
module bootloader_packet_command_engine_core_checker
    import bpce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  op,
    input  logic [4:0]            byte_index,
    input  logic [7:0]            byte_value,
    input  logic [31:0]           old_word,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [1:0]            event_res,
    input  logic                  reply_status,
    input  logic [31:0]           flash_block,
    input  logic [7:0]            word_index,
    input  logic [31:0]           new_word,
    input  logic                  erase_needed,
    input  logic                  write_needed,
    input  logic                  last,
    output int                    errors,
    output int                    pending,
    output int                    results_seen,
    output int                    checks_done,
    output int                    beats_in
);

    localparam int BUF_BYTES       = BUFFER_BYTES_DEF;
    localparam int PKT_BYTES       = PACKET_BYTES_DEF;
    localparam int CHUNK           = CHUNK_BYTES_DEF;
    localparam int WORDS_PER_CHECK = BUF_BYTES / 4;
    localparam int PRINT_CAP       = 40;

    // mirrored config and engine state
    logic [31:0]          first_block;
    logic [31:0]          limit_block;
    logic [7:0]           load_data [BUF_BYTES];
    bit [BUF_BYTES-1:0]   loaded;
    logic                 serving;
    logic                 header_match;
    logic [7:0]           subcmd;
    logic [31:0]          block_no;
    logic                 checking;
    int unsigned          check_idx;
    logic                 erase_seen;
    logic                 diff_seen;

    result_t expected_q[$];

    initial begin
        errors       = 0;
        pending      = 0;
        results_seen = 0;
        checks_done  = 0;
        beats_in     = 0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got,
                     want);
    endtask

    // unwritten bytes read back as erased flash
    function automatic logic [7:0] buffered_byte(input int unsigned a);
        if (a >= BUF_BYTES || !loaded[a])
            return 8'hff;
        return load_data[a];
    endfunction

    function automatic logic [31:0] buffered_word(input int unsigned w);
        return {buffered_byte(4 * w + 3), buffered_byte(4 * w + 2),
                buffered_byte(4 * w + 1), buffered_byte(4 * w)};
    endfunction

    // advance the mirror by one accepted input beat
    task automatic take_beat(input logic b_op, input logic [4:0] idx, input logic [7:0] val,
                             input logic [31:0] old, output bit made, output result_t res);
        logic [31:0] nw;
        int unsigned addr;
        int          pos;
        bit          do_boot;
        made    = 1'b0;
        do_boot = 1'b0;
        res     = '0;
        pos     = idx;
        if (b_op == OP_FLASH) begin
            // flash words only matter while a check runs
            if (checking) begin
                nw = buffered_word(check_idx);
                if ((~old & nw) != 32'd0)
                    erase_seen = 1'b1;
                if (old != nw)
                    diff_seen = 1'b1;
                made            = 1'b1;
                res.ev          = EV_WORD;
                res.flash_block = block_no;
                res.word_index  = check_idx[7:0];
                res.new_word    = nw;
                if (check_idx + 1 >= WORDS_PER_CHECK) begin
                    res.erase = erase_seen;
                    res.write = diff_seen;
                    res.last  = 1'b1;
                    checking  = 1'b0;
                    check_idx = 0;
                    loaded    = '0;
                end
                else begin
                    check_idx++;
                end
            end
        end
        else if (!checking && pos < PKT_BYTES) begin
            if (pos == 0)
                header_match = (val == HDR_CMD);
            else if (pos == 1)
                subcmd = val;
            if (pos >= 2 && pos <= 5)
                block_no[8 * (pos - 2) +: 8] = val;
            if (serving && header_match && subcmd <= SUB_LOAD_MAX && pos >= 2 &&
                pos < 2 + CHUNK) begin
                addr = subcmd * CHUNK + pos - 2;
                // chunks past the buffer end are clipped
                if (addr < BUF_BYTES) begin
                    load_data[addr] = val;
                    loaded[addr]    = 1'b1;
                end
            end
            if (pos == PKT_BYTES - 1) begin
                if (!serving) begin
                    if (header_match && subcmd == SUB_ENTER) begin
                        serving    = 1'b1;
                        loaded     = '0;
                        made       = 1'b1;
                        res.status = STATUS_OK;
                    end
                    else begin
                        do_boot = 1'b1;
                    end
                end
                else if (!header_match) begin
                    do_boot = 1'b1;
                end
                else if (subcmd == SUB_FLASH) begin
                    if (block_no < first_block || block_no >= limit_block) begin
                        loaded     = '0;
                        made       = 1'b1;
                        res.status = STATUS_BAD;
                    end
                    else begin
                        checking   = 1'b1;
                        check_idx  = 0;
                        erase_seen = 1'b0;
                        diff_seen  = 1'b0;
                    end
                end
                else if (subcmd == SUB_TO_APP || subcmd == SUB_EXIT) begin
                    do_boot = 1'b1;
                end
                else if (subcmd == SUB_ENTER) begin
                    loaded     = '0;
                    made       = 1'b1;
                    res.status = STATUS_OK;
                end
                if (do_boot) begin
                    serving  = 1'b0;
                    checking = 1'b0;
                    loaded   = '0;
                    made     = 1'b1;
                    res.ev   = EV_BOOT;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t want;
        result_t nxt;
        bit      made;
        if (!rst_n) begin
            first_block  = FIRST_BLOCK_RESET;
            limit_block  = BLOCK_LIMIT_RESET;
            loaded       = '0;
            serving      = 1'b0;
            header_match = 1'b0;
            subcmd       = 8'd0;
            block_no     = 32'd0;
            checking     = 1'b0;
            check_idx    = 0;
            erase_seen   = 1'b0;
            diff_seen    = 1'b0;
            expected_q.delete();
            pending     <= 0;
        end
        else begin
            // config port: track writes, check reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_FIRST_BLOCK)
                        first_block = pwdata;
                    else
                        limit_block = pwdata;
                end
                else if (prdata != ((paddr[2] == REG_FIRST_BLOCK) ? first_block
                                                                  : limit_block)) begin
                    report("config readback", prdata,
                           (paddr[2] == REG_FIRST_BLOCK) ? first_block : limit_block);
                end
            end
            // results are checked before this edge's input is predicted
            if (out_valid && out_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report("result beat with nothing expected", event_res, 32'd0);
                end
                else begin
                    want = expected_q.pop_front();
                    if (want.last)
                        checks_done++;
                    if (event_res != want.ev)
                        report("event_res", event_res, want.ev);
                    if (reply_status != want.status)
                        report("reply_status", reply_status, want.status);
                    if (flash_block != want.flash_block)
                        report("flash_block", flash_block, want.flash_block);
                    if (word_index != want.word_index)
                        report("word_index", word_index, want.word_index);
                    if (new_word != want.new_word)
                        report("new_word", new_word, want.new_word);
                    if (erase_needed != want.erase)
                        report("erase_needed", erase_needed, want.erase);
                    if (write_needed != want.write)
                        report("write_needed", write_needed, want.write);
                    if (last != want.last)
                        report("last", last, want.last);
                end
            end
            if (in_valid && in_ready) begin
                beats_in++;
                take_beat(op, byte_index, byte_value, old_word, made, nxt);
                if (made)
                    expected_q.push_back(nxt);
            end
            pending <= expected_q.size();
        end
    end

endmodule

/* tb/bootloader_packet_command_engine_core_test.sv */
`timescale 1ns / 1ps
// top of the bootloader packet command engine testbench: clock, reset, stimulus and
// verdict; depends on bpce_pkg, the engine rtl and the scoreboard module
module bootloader_packet_command_engine_core_test;
    import bpce_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;     // settling margin once no result is pending
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int PHASE_BEATS   = 300;   // random beats per config setting
    localparam int PKT_LAST      = PACKET_BYTES_DEF - 1;
    localparam int CHECK_WORDS   = BUFFER_BYTES_DEF / 4;
    localparam int FILL_RANDOM   = -1;

    // old flash contents offered during a check
    localparam int OLD_ERASED = 0;
    localparam int OLD_ZERO   = 1;
    localparam int OLD_MIXED  = 2;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = OP_BYTE;
    logic [4:0]            byte_index = '0;
    logic [7:0]            byte_value = '0;
    logic [31:0]           old_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            event_res;
    logic                  reply_status;
    logic [31:0]           flash_block;
    logic [7:0]            word_index;
    logic [31:0]           new_word;
    logic                  erase_needed;
    logic                  write_needed;
    logic                  last;

    int errors;
    int pending;
    int results_seen;
    int checks_done;
    int beats_in;

    // stimulus-side view of the block window, kept in step with the writes
    logic [31:0] cfg_first = FIRST_BLOCK_RESET;
    logic [31:0] cfg_limit = BLOCK_LIMIT_RESET;
    int          beats_sent = 0;
    int          burst_left = 0;
    int          settings_used = 1;
    int          cycle_count = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    bootloader_packet_command_engine_core u_dut (.*);

    bootloader_packet_command_engine_core_checker u_checker (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog: a correct run ends far below this
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bootloader_packet_command_engine_core_test: done, errors");
        $finish;
    end

    // receiver: random ready patterns in spans, plus one long hold-off on request
    initial begin : receiver
        int mode;
        int span;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
                repeat (span) begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // one input beat; bursts of random length separated by random gaps
    task automatic send_beat(input logic b_op, input logic [4:0] idx, input logic [7:0] val,
                             input logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                // long stretch with no idling
                burst_left = $urandom_range(100, 300);
                gap        = 0;
            end
            else begin
                burst_left = $urandom_range(1, 40);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        op         <= b_op;
        byte_index <= idx;
        byte_value <= val;
        old_word   <= word;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // packet bytes 0..upto in order; bytes 2..5 carry blk unless a fill byte is given
    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] sub,
                               input logic [31:0] blk, input int fill, input int upto);
        logic [7:0] b;
        for (int i = 0; i <= upto; i++) begin
            if (i == 0)
                b = hdr;
            else if (i == 1)
                b = sub;
            else if (fill != FILL_RANDOM)
                b = 8'(fill);
            else if (i <= 5)
                b = blk[8 * (i - 2) +: 8];
            else
                b = 8'($urandom);
            send_beat(OP_BYTE, 5'(i), b, $urandom);
            beats_sent++;
        end
    endtask

    // one full flash check; a packet dropped in mid-check must be ignored
    task automatic send_check(input int mode, input bit mid_packet);
        logic [31:0] w;
        for (int i = 0; i < CHECK_WORDS; i++) begin
            if (mid_packet && i == 16)
                send_packet(HDR_CMD, SUB_TO_APP, $urandom, FILL_RANDOM, PKT_LAST);
            case (mode)
                OLD_ERASED: w = 32'hffff_ffff;
                OLD_ZERO:   w = 32'd0;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       w = $urandom;
                        1:       w = 32'd0;
                        default: w = 32'hffff_ffff;
                    endcase
                end
            endcase
            send_beat(OP_FLASH, 5'($urandom), 8'($urandom), w);
            beats_sent++;
        end
    endtask

    task automatic flash_cmd(input logic [31:0] blk, input int mode, input bit mid_packet);
        send_packet(HDR_CMD, SUB_FLASH, blk, FILL_RANDOM, PKT_LAST);
        if (blk >= cfg_first && blk < cfg_limit)
            send_check(mode, mid_packet);
    endtask

    function automatic logic [31:0] pick_block(input bit want_ok);
        logic [31:0] b;
        if (want_ok && cfg_first < cfg_limit) begin
            case ($urandom_range(0, 2))
                0:       b = cfg_first;
                1:       b = cfg_limit - 1;
                default: b = $urandom_range(cfg_first, cfg_limit - 1);
            endcase
        end
        else begin
            b = $urandom;
            if ($urandom_range(0, 1) == 0 && cfg_first != 32'd0)
                b = cfg_first - 1;
            else if ($urandom_range(0, 1) == 0 || (b >= cfg_first && b < cfg_limit))
                b = cfg_limit;
        end
        return b;
    endfunction

    // apb access: setup phase, access phase, then idle
    task automatic cfg_access(input logic wr, input logic sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (wr && sel == REG_FIRST_BLOCK)
            cfg_first = value;
        else if (wr)
            cfg_limit = value;
    endtask

    // stop offering and wait for every expected result, then let the engine settle
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [31:0] first, input logic [31:0] limit);
        drain();
        cfg_access(1'b1, REG_FIRST_BLOCK, first);
        cfg_access(1'b1, REG_BLOCK_LIMIT, limit);
        cfg_access(1'b0, REG_FIRST_BLOCK, 32'd0);
        cfg_access(1'b0, REG_BLOCK_LIMIT, 32'd0);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_load_sub();
        case ($urandom_range(0, 3))
            0:       return SUB_LOAD_MAX;
            1:       return SUB_LOAD_MAX - 1;
            default: return 8'($urandom_range(0, SUB_LOAD_MAX));
        endcase
    endfunction

    function automatic int pick_fill();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // handshake, some loads, then a closing command; mostly well formed
    task automatic random_session();
        int          n;
        int          pick;
        logic [31:0] blk;
        bit          want_ok;
        send_packet(HDR_CMD, SUB_ENTER, $urandom, FILL_RANDOM, PKT_LAST);
        n = $urandom_range(0, 6);
        repeat (n) send_packet(HDR_CMD, pick_load_sub(), $urandom, pick_fill(), PKT_LAST);
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            want_ok = ($urandom_range(0, 3) != 0);
            blk     = pick_block(want_ok);
            // first check of the random part doubles as the back-pressure test
            if (blk >= cfg_first && blk < cfg_limit)
                hold_req = 1'b1;
            flash_cmd(blk, $urandom_range(OLD_ERASED, OLD_MIXED), $urandom_range(0, 3) == 0);
        end
        else if (pick < 7) begin
            send_packet(HDR_CMD, SUB_ENTER, $urandom, FILL_RANDOM, PKT_LAST);
        end
        else if (pick == 7) begin
            send_packet(HDR_CMD, $urandom_range(0, 1) ? SUB_TO_APP : SUB_EXIT, $urandom,
                        FILL_RANDOM, PKT_LAST);
        end
        else begin
            send_packet(HDR_CMD, 8'($urandom_range(SUB_LOAD_MAX + 1, 250)), $urandom,
                        FILL_RANDOM, PKT_LAST);
        end
    endtask

    task automatic random_beats(input int target);
        int pick;
        int n;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) begin
                random_session();
            end
            else if (pick < 14) begin
                // loose packet: odd header or any subcommand
                send_packet(($urandom_range(0, 3) == 0) ? 8'($urandom) : HDR_CMD,
                            8'($urandom), $urandom, pick_fill(), PKT_LAST);
            end
            else if (pick < 16) begin
                // truncated packet, the next one restarts at byte 0
                send_packet(HDR_CMD, 8'($urandom), $urandom, FILL_RANDOM,
                            $urandom_range(0, PKT_LAST - 1));
            end
            else if (pick < 18) begin
                n = $urandom_range(1, 6);
                repeat (n) send_beat($urandom_range(0, 1), 5'($urandom), 8'($urandom),
                                     $urandom);
            end
            else begin
                // flash words with no check running
                n = $urandom_range(1, 4);
                repeat (n) send_beat(OP_FLASH, 5'($urandom), 8'($urandom), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] base;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, default window 4..1023
        send_packet(8'h00, 8'h00, 32'd0, 8'h00, PKT_LAST);          // no handshake: boot
        send_packet(HDR_CMD, 8'h00, 32'd0, 8'hff, PKT_LAST);        // load before handshake
        send_beat(OP_FLASH, 5'd0, 8'd0, 32'hdead_beef);              // word outside a check
        send_packet(HDR_CMD, SUB_ENTER, $urandom, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, 8'd0, 32'd0, 8'h00, PKT_LAST);
        send_packet(HDR_CMD, SUB_LOAD_MAX, 32'd0, FILL_RANDOM, PKT_LAST); // clipped chunk
        flash_cmd(cfg_first - 1, OLD_ERASED, 1'b0);                  // below window
        send_packet(HDR_CMD, 8'd1, 32'd0, 8'hff, PKT_LAST);
        flash_cmd(cfg_limit, OLD_ERASED, 1'b0);                      // at the limit
        send_packet(HDR_CMD, SUB_LOAD_MAX - 1, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, SUB_LOAD_MAX, 32'd0, FILL_RANDOM, PKT_LAST);
        flash_cmd(cfg_first, OLD_ZERO, 1'b1);                        // erase and write
        flash_cmd(cfg_limit - 1, OLD_ERASED, 1'b0);                  // nothing to do
        send_packet(HDR_CMD, 8'd5, 32'd0, 8'h00, PKT_LAST);
        flash_cmd(32'd500, OLD_ERASED, 1'b0);                        // write, no erase
        send_packet(HDR_CMD, SUB_LOAD_MAX + 1, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, 8'hff, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, SUB_ENTER, 32'd0, FILL_RANDOM, PKT_LAST); // reply while serving
        send_packet(8'h00, 8'd0, 32'd0, FILL_RANDOM, PKT_LAST);     // bad header: boot
        send_packet(HDR_CMD, SUB_ENTER, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, SUB_TO_APP, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, SUB_ENTER, 32'd0, FILL_RANDOM, PKT_LAST);
        send_packet(HDR_CMD, SUB_EXIT, 32'd0, FILL_RANDOM, PKT_LAST);

        // random part over several block windows, extremes included
        set_window(32'd0, 32'hffff_ffff);
        random_beats(beats_sent + PHASE_BEATS);
        base = $urandom_range(0, 32'hffff_0000);
        set_window(base, base + $urandom_range(1, 4096));
        random_beats(beats_sent + PHASE_BEATS);
        set_window(32'hffff_ffff, 32'd0);                            // nothing is valid
        random_beats(beats_sent + PHASE_BEATS);
        set_window(32'd1, 32'd2);                                    // single valid block
        random_beats(beats_sent + PHASE_BEATS);

        drain();
        $display("covered %0d input beats and %0d result beats, %0d full flash checks",
                 beats_in, results_seen, checks_done);
        $display("block window settings used: %0d, long receiver hold-off done: %0d",
                 settings_used, hold_done);
        if (errors == 0)
            $display("bootloader_packet_command_engine_core_test: done, clean");
        else
            $display("bootloader_packet_command_engine_core_test: done, errors");
        $finish;
    end

endmodule
